### src/cdo_pkg.sv
// cdo_pkg: shared types, constants and the month length table for the
// calendar date offset core. No dependencies.
package cdo_pkg;

   // field widths of the stream words
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 12;
   localparam int AMT_W   = 16;
   localparam int UNIT_W  = 2;

   // signed width of a target year: start year plus or minus the amount
   localparam int TY_W = 18;

   // calendar constants
   localparam int FIRST_YEAR = 1900;
   localparam int DAYS_COMMON = 365;
   localparam int DAYS_LEAP   = 366;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_LEAP  = 5'd29;

   // unit codes
   localparam logic [UNIT_W-1:0] UNIT_DAYS  = 2'd0;
   localparam logic [UNIT_W-1:0] UNIT_WEEKS = 2'd1;
   localparam logic [UNIT_W-1:0] UNIT_YEARS = 2'd2;
   localparam logic [UNIT_W-1:0] UNIT_NONE  = 2'd3;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_ADD_YEAR,
      OP_ADD_MONTH,
      OP_CLR_FLAG,
      OP_YEAR_OFFSET,
      OP_YR_RESET,
      OP_INC_YEAR,
      OP_SET_YEAR,
      OP_DAY_OFFSET,
      OP_SUB_YEAR,
      OP_SUB_MONTH,
      OP_SET_DAYS,
      OP_EMIT
   } dp_op_type;

   // jump conditions
   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_REQ,
      CND_BAD_MY,
      CND_YR_EQ_TY,
      CND_MO_EQ_SM,
      CND_DAY_BAD,
      CND_UNIT_NOT3,
      CND_UNIT_NOT2,
      CND_TY_BAD,
      CND_NUM_BAD,
      CND_NUM_LE_YD,
      CND_MW_DONE,
      CND_RSP_BUSY
   } cond_type;

   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_type;

   // program addresses
   localparam step_type STEP_IDLE        = 5'd0;
   localparam step_type STEP_CHK_MY      = 5'd1;
   localparam step_type STEP_YWALK       = 5'd2;
   localparam step_type STEP_MWALK       = 5'd3;
   localparam step_type STEP_CHK_DAY     = 5'd4;
   localparam step_type STEP_UNIT_NONE   = 5'd5;
   localparam step_type STEP_GO_EMIT     = 5'd6;
   localparam step_type STEP_YEAR_OFS    = 5'd7;
   localparam step_type STEP_YEAR_CHK    = 5'd8;
   localparam step_type STEP_YEAR_WALK   = 5'd9;
   localparam step_type STEP_YEAR_SET    = 5'd10;
   localparam step_type STEP_YEAR_DONE   = 5'd11;
   localparam step_type STEP_DAY_OFS     = 5'd12;
   localparam step_type STEP_DAY_CHK     = 5'd13;
   localparam step_type STEP_SPLIT_YEAR  = 5'd14;
   localparam step_type STEP_SPLIT_MONTH = 5'd15;
   localparam step_type STEP_DAY_SET     = 5'd16;
   localparam step_type STEP_EMIT        = 5'd17;
   localparam step_type STEP_RETURN      = 5'd18;

   // one control word: op runs when the condition misses
   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      step_type  jmp;
      logic      loop;
   } ucode_word_type;

   typedef struct packed {
      dp_op_type op;
      logic      en;
   } dp_ctrl_type;

   typedef struct packed {
      logic req_fire;
      logic bad_my;
      logic yr_eq_ty;
      logic mo_eq_sm;
      logic day_bad;
      logic unit_not3;
      logic unit_not2;
      logic ty_bad;
      logic num_bad;
      logic num_le_yd;
      logic mw_done;
      logic rsp_busy;
   } dp_status_type;

   // days in a month, february by leap flag
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (mo)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

### src/cdo_ucode_rom.sv
// cdo_ucode_rom: the control program of the date offset core, one word per step.
// Depends on cdo_pkg.
module cdo_ucode_rom import cdo_pkg::*; (
   input  step_type       pc,
   output ucode_word_type word
);

   // program table
   always_comb begin
      case (pc)
         // wait for a word, latch it and clear the year walker
         STEP_IDLE:        word = '{OP_LOAD,        CND_NO_REQ,    STEP_IDLE,        1'b0};
         STEP_CHK_MY:      word = '{OP_NOP,         CND_BAD_MY,    STEP_EMIT,        1'b0};
         // start date to day number
         STEP_YWALK:       word = '{OP_ADD_YEAR,    CND_YR_EQ_TY,  STEP_MWALK,       1'b1};
         STEP_MWALK:       word = '{OP_ADD_MONTH,   CND_MO_EQ_SM,  STEP_CHK_DAY,     1'b1};
         STEP_CHK_DAY:     word = '{OP_NOP,         CND_DAY_BAD,   STEP_EMIT,        1'b0};
         // unknown unit returns the start date
         STEP_UNIT_NONE:   word = '{OP_CLR_FLAG,    CND_UNIT_NOT3, STEP_YEAR_OFS,    1'b0};
         STEP_GO_EMIT:     word = '{OP_NOP,         CND_ALWAYS,    STEP_EMIT,        1'b0};
         // year shift
         STEP_YEAR_OFS:    word = '{OP_YEAR_OFFSET, CND_UNIT_NOT2, STEP_DAY_OFS,     1'b0};
         STEP_YEAR_CHK:    word = '{OP_YR_RESET,    CND_TY_BAD,    STEP_EMIT,        1'b0};
         STEP_YEAR_WALK:   word = '{OP_INC_YEAR,    CND_YR_EQ_TY,  STEP_YEAR_SET,    1'b1};
         STEP_YEAR_SET:    word = '{OP_SET_YEAR,    CND_NEVER,     STEP_IDLE,        1'b0};
         STEP_YEAR_DONE:   word = '{OP_NOP,         CND_ALWAYS,    STEP_EMIT,        1'b0};
         // day or week shift, then day number back to a date
         STEP_DAY_OFS:     word = '{OP_DAY_OFFSET,  CND_NEVER,     STEP_IDLE,        1'b0};
         STEP_DAY_CHK:     word = '{OP_YR_RESET,    CND_NUM_BAD,   STEP_EMIT,        1'b0};
         STEP_SPLIT_YEAR:  word = '{OP_SUB_YEAR,    CND_NUM_LE_YD, STEP_SPLIT_MONTH, 1'b1};
         STEP_SPLIT_MONTH: word = '{OP_SUB_MONTH,   CND_MW_DONE,   STEP_DAY_SET,     1'b1};
         STEP_DAY_SET:     word = '{OP_SET_DAYS,    CND_NEVER,     STEP_IDLE,        1'b0};
         // hand the result to the output register
         STEP_EMIT:        word = '{OP_EMIT,        CND_RSP_BUSY,  STEP_EMIT,        1'b0};
         STEP_RETURN:      word = '{OP_NOP,         CND_ALWAYS,    STEP_IDLE,        1'b0};
         default:          word = '{OP_NOP,         CND_ALWAYS,    STEP_IDLE,        1'b0};
      endcase
   end

endmodule

### src/cdo_sequencer.sv
// cdo_sequencer: step counter and conditional jump logic of the date offset core.
// Depends on cdo_pkg.
module cdo_sequencer import cdo_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  ucode_word_type word,
   input  dp_status_type  status,
   output step_type       pc,
   output dp_ctrl_type    ctrl
);

   step_type pc_ff;
   step_type pc_in;
   logic     cond_hit;

   // condition select
   always_comb begin
      case (word.cond)
         CND_NEVER:     cond_hit = 1'b0;
         CND_ALWAYS:    cond_hit = 1'b1;
         CND_NO_REQ:    cond_hit = !status.req_fire;
         CND_BAD_MY:    cond_hit = status.bad_my;
         CND_YR_EQ_TY:  cond_hit = status.yr_eq_ty;
         CND_MO_EQ_SM:  cond_hit = status.mo_eq_sm;
         CND_DAY_BAD:   cond_hit = status.day_bad;
         CND_UNIT_NOT3: cond_hit = status.unit_not3;
         CND_UNIT_NOT2: cond_hit = status.unit_not2;
         CND_TY_BAD:    cond_hit = status.ty_bad;
         CND_NUM_BAD:   cond_hit = status.num_bad;
         CND_NUM_LE_YD: cond_hit = status.num_le_yd;
         CND_MW_DONE:   cond_hit = status.mw_done;
         CND_RSP_BUSY:  cond_hit = status.rsp_busy;
         default:       cond_hit = 1'b1;
      endcase
   end

   // next step: jump on hit, else hold in a loop or advance
   always_comb begin
      if (cond_hit) begin
         pc_in = word.jmp;
      end else if (word.loop) begin
         pc_in = pc_ff;
      end else begin
         pc_in = STEP_W'(pc_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign pc        = pc_ff;
   assign ctrl.op   = word.op;
   assign ctrl.en   = !cond_hit;

endmodule

### src/cdo_datapath.sv
// cdo_datapath: working registers, year and month walker, day number adder,
// result register and output register of the date offset core. Depends on cdo_pkg.
module cdo_datapath import cdo_pkg::*; #(
   parameter int YEAR_SPAN = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_ctrl_type        ctrl,
   input  logic               req_fire,
   input  logic [DAY_W-1:0]   req_day,
   input  logic [MONTH_W-1:0] req_month,
   input  logic [YEAR_W-1:0]  req_year,
   input  logic               req_dir,
   input  logic [AMT_W-1:0]   req_amount,
   input  logic [UNIT_W-1:0]  req_unit,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [DAY_W-1:0]   rsp_day,
   output logic [MONTH_W-1:0] rsp_month,
   output logic [YEAR_W-1:0]  rsp_year,
   output logic               rsp_flag,
   output dp_status_type      status
);

   localparam int LAST_YEAR = FIRST_YEAR + YEAR_SPAN - 1;
   localparam int YR_BITS   = $clog2(LAST_YEAR + 1);
   localparam int YR_W      = (YR_BITS > YEAR_W) ? YR_BITS : YEAR_W;
   localparam int PREV_YEAR = FIRST_YEAR - 1;
   localparam int LEAPS     = (LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400)
                            - (PREV_YEAR / 4 - PREV_YEAR / 100 + PREV_YEAR / 400);
   localparam int TOTAL_DAYS = YEAR_SPAN * DAYS_COMMON + LEAPS;
   localparam int MAX_DELTA  = ((1 << AMT_W) - 1) * 7;
   localparam int NUM_W      = $clog2(TOTAL_DAYS + MAX_DELTA + 1) + 1;
   localparam int DELTA_W    = AMT_W + 3;
   localparam logic [1:0] C4_INIT   = 2'(FIRST_YEAR % 4);
   localparam logic [6:0] C100_INIT = 7'(FIRST_YEAR % 100);
   localparam logic [8:0] C400_INIT = 9'(FIRST_YEAR % 400);
   localparam logic [6:0] C100_LAST = 7'd99;
   localparam logic [8:0] C400_LAST = 9'd399;

   // latched request word
   logic [DAY_W-1:0]   sd_ff, sd_in;
   logic [MONTH_W-1:0] sm_ff, sm_in;
   logic [YEAR_W-1:0]  sy_ff, sy_in;
   logic               dir_ff, dir_in;
   logic [AMT_W-1:0]   amt_ff, amt_in;
   logic [UNIT_W-1:0]  unit_ff, unit_in;

   // walker and working values
   logic [YR_W-1:0]          yr_ff, yr_in;
   logic [1:0]               c4_ff, c4_in;
   logic [6:0]               c100_ff, c100_in;
   logic [8:0]               c400_ff, c400_in;
   logic [MONTH_W-1:0]       mo_ff, mo_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic signed [TY_W-1:0]   ty_ff, ty_in;

   // result register
   logic [DAY_W-1:0]   res_day_ff, res_day_in;
   logic [MONTH_W-1:0] res_month_ff, res_month_in;
   logic [YEAR_W-1:0]  res_year_ff, res_year_in;
   logic               res_flag_ff, res_flag_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // output register, held while the word waits for the receiver
   logic [DAY_W-1:0]   out_day_ff, out_day_in;
   logic [MONTH_W-1:0] out_month_ff, out_month_in;
   logic [YEAR_W-1:0]  out_year_ff, out_year_in;
   logic               out_flag_ff, out_flag_in;

   logic                    leap;
   logic [8:0]              ydays;
   logic [DAY_W-1:0]        mdays;
   logic [DELTA_W-1:0]      delta;
   logic signed [NUM_W-1:0] delta_s;
   logic signed [NUM_W-1:0] ydays_s;
   logic signed [NUM_W-1:0] mdays_s;
   logic                    leap_fix;

   // leap flag of the walker year from its running remainders
   assign leap    = (c4_ff == 2'd0) && ((c100_ff != 7'd0) || (c400_ff == 9'd0));
   assign ydays   = leap ? 9'(DAYS_LEAP) : 9'(DAYS_COMMON);
   assign mdays   = month_len(mo_ff, leap);
   assign ydays_s = $signed(NUM_W'(ydays));
   assign mdays_s = $signed(NUM_W'(mdays));

   // day offset: amount, or amount times seven as shift and subtract
   assign delta = (unit_ff == UNIT_WEEKS) ? ({amt_ff, 3'b000} - DELTA_W'(amt_ff))
                                          : DELTA_W'(amt_ff);
   assign delta_s = $signed(NUM_W'(delta));

   assign leap_fix = (sm_ff == MONTH_FEB) && (sd_ff == DAY_LEAP) && !leap;

   // status for the jump conditions
   always_comb begin
      status.req_fire  = req_fire;
      status.bad_my    = (sm_ff == 4'd0) || (sm_ff > MONTH_DEC)
                      || (YR_W'(sy_ff) < YR_W'(FIRST_YEAR))
                      || (YR_W'(sy_ff) > YR_W'(LAST_YEAR));
      status.yr_eq_ty  = ($signed(TY_W'(yr_ff)) == ty_ff);
      status.mo_eq_sm  = (mo_ff == sm_ff);
      status.day_bad   = (sd_ff == 5'd0) || (sd_ff > mdays);
      status.unit_not3 = (unit_ff != UNIT_NONE);
      status.unit_not2 = (unit_ff != UNIT_YEARS);
      status.ty_bad    = (ty_ff < TY_W'(FIRST_YEAR)) || (ty_ff > TY_W'(LAST_YEAR));
      status.num_bad   = (num_ff < NUM_W'(1)) || (num_ff > NUM_W'(TOTAL_DAYS));
      status.num_le_yd = (num_ff <= ydays_s);
      status.mw_done   = (mo_ff == MONTH_DEC) || (num_ff <= mdays_s);
      status.rsp_busy  = rsp_valid_ff;
   end

   // operation decode
   always_comb begin
      sd_in        = sd_ff;
      sm_in        = sm_ff;
      sy_in        = sy_ff;
      dir_in       = dir_ff;
      amt_in       = amt_ff;
      unit_in      = unit_ff;
      yr_in        = yr_ff;
      c4_in        = c4_ff;
      c100_in      = c100_ff;
      c400_in      = c400_ff;
      mo_in        = mo_ff;
      num_in       = num_ff;
      ty_in        = ty_ff;
      res_day_in   = res_day_ff;
      res_month_in = res_month_ff;
      res_year_in  = res_year_ff;
      res_flag_in  = res_flag_ff;
      rsp_valid_in = rsp_valid_ff;
      out_day_in   = out_day_ff;
      out_month_in = out_month_ff;
      out_year_in  = out_year_ff;
      out_flag_in  = out_flag_ff;

      // output word taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctrl.en) begin
         case (ctrl.op)
            OP_LOAD: begin
               sd_in        = req_day;
               sm_in        = req_month;
               sy_in        = req_year;
               dir_in       = req_dir;
               amt_in       = req_amount;
               unit_in      = req_unit;
               res_day_in   = req_day;
               res_month_in = req_month;
               res_year_in  = req_year;
               res_flag_in  = 1'b1;
               yr_in        = YR_W'(FIRST_YEAR);
               c4_in        = C4_INIT;
               c100_in      = C100_INIT;
               c400_in      = C400_INIT;
               mo_in        = MONTH_JAN;
               num_in       = $signed(NUM_W'(req_day));
               ty_in        = $signed(TY_W'(req_year));
            end
            OP_ADD_YEAR, OP_INC_YEAR, OP_SUB_YEAR: begin
               yr_in   = YR_W'(yr_ff + 1'b1);
               c4_in   = 2'(c4_ff + 1'b1);
               c100_in = (c100_ff == C100_LAST) ? 7'd0 : 7'(c100_ff + 1'b1);
               c400_in = (c400_ff == C400_LAST) ? 9'd0 : 9'(c400_ff + 1'b1);
               if (ctrl.op == OP_ADD_YEAR) begin
                  num_in = num_ff + ydays_s;
               end else if (ctrl.op == OP_SUB_YEAR) begin
                  num_in = num_ff - ydays_s;
               end
            end
            OP_ADD_MONTH: begin
               num_in = num_ff + mdays_s;
               mo_in  = MONTH_W'(mo_ff + 1'b1);
            end
            OP_SUB_MONTH: begin
               num_in = num_ff - mdays_s;
               mo_in  = MONTH_W'(mo_ff + 1'b1);
            end
            OP_CLR_FLAG: begin
               res_flag_in = 1'b0;
            end
            OP_YEAR_OFFSET: begin
               if (dir_ff) begin
                  ty_in = $signed(TY_W'(sy_ff) - TY_W'(amt_ff));
               end else begin
                  ty_in = $signed(TY_W'(sy_ff) + TY_W'(amt_ff));
               end
            end
            OP_YR_RESET: begin
               yr_in   = YR_W'(FIRST_YEAR);
               c4_in   = C4_INIT;
               c100_in = C100_INIT;
               c400_in = C400_INIT;
               mo_in   = MONTH_JAN;
            end
            OP_SET_YEAR: begin
               res_day_in   = leap_fix ? DAY_FIRST : sd_ff;
               res_month_in = leap_fix ? MONTH_MAR : sm_ff;
               res_year_in  = ty_ff[YEAR_W-1:0];
               res_flag_in  = 1'b0;
            end
            OP_DAY_OFFSET: begin
               num_in = dir_ff ? (num_ff - delta_s) : (num_ff + delta_s);
            end
            OP_SET_DAYS: begin
               res_day_in   = num_ff[DAY_W-1:0];
               res_month_in = mo_ff;
               res_year_in  = yr_ff[YEAR_W-1:0];
               res_flag_in  = 1'b0;
            end
            OP_EMIT: begin
               rsp_valid_in = 1'b1;
               out_day_in   = res_day_ff;
               out_month_in = res_month_ff;
               out_year_in  = res_year_ff;
               out_flag_in  = res_flag_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sd_ff        <= sd_in;
      sm_ff        <= sm_in;
      sy_ff        <= sy_in;
      dir_ff       <= dir_in;
      amt_ff       <= amt_in;
      unit_ff      <= unit_in;
      yr_ff        <= yr_in;
      c4_ff        <= c4_in;
      c100_ff      <= c100_in;
      c400_ff      <= c400_in;
      mo_ff        <= mo_in;
      num_ff       <= num_in;
      ty_ff        <= ty_in;
      res_day_ff   <= res_day_in;
      res_month_ff <= res_month_in;
      res_year_ff  <= res_year_in;
      res_flag_ff  <= res_flag_in;
      out_day_ff   <= out_day_in;
      out_month_ff <= out_month_in;
      out_year_ff  <= out_year_in;
      out_flag_ff  <= out_flag_in;
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_day   = out_day_ff;
   assign rsp_month = out_month_ff;
   assign rsp_year  = out_year_ff;
   assign rsp_flag  = out_flag_ff;

endmodule

### src/calendar_date_offset_core.sv
// calendar_date_offset_core: top level of the date offset core, joining the
// control program, the sequencer and the datapath. Depends on cdo_pkg.
//
// Moves a start date by a number of days, weeks or years and returns the new
// day, month and year; years span 1900 to 1900 + YEAR_SPAN - 1 and follow the
// Gregorian leap rule. An invalid start date or a result outside the span
// comes back as the start date with out_of_range set. One word is worked at a
// time by a microcoded walker that steps one year or one month per clock;
// the result can then wait for the output register to free up. A new
// request word is taken once the previous result sits in the output
// register.
module calendar_date_offset_core import cdo_pkg::*; #(
   parameter int YEAR_SPAN = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_day, start_month, start_year, direction, amount, zero pad
   input  logic [39:0] req_tdata,
   // unit
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_day, result_month, result_year, zero pad
   output logic [23:0] rsp_tdata,
   // out_of_range
   output logic [0:0]  rsp_tuser
);

   step_type       pc;
   ucode_word_type word;
   dp_ctrl_type    ctrl;
   dp_status_type  status;
   logic           req_fire;

   logic [DAY_W-1:0]   rsp_day;
   logic [MONTH_W-1:0] rsp_month;
   logic [YEAR_W-1:0]  rsp_year;
   logic               rsp_flag;

   // accept only while the program waits at its idle step
   assign req_tready = (pc == STEP_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   cdo_ucode_rom u_rom (
      .pc   (pc),
      .word (word)
   );

   cdo_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .word   (word),
      .status (status),
      .pc     (pc),
      .ctrl   (ctrl)
   );

   cdo_datapath #(
      .YEAR_SPAN (YEAR_SPAN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_fire   (req_fire),
      .req_day    (req_tdata[4:0]),
      .req_month  (req_tdata[8:5]),
      .req_year   (req_tdata[20:9]),
      .req_dir    (req_tdata[21]),
      .req_amount (req_tdata[37:22]),
      .req_unit   (req_tuser),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_day    (rsp_day),
      .rsp_month  (rsp_month),
      .rsp_year   (rsp_year),
      .rsp_flag   (rsp_flag),
      .status     (status)
   );

   // pack the result word
   assign rsp_tdata = {3'b000, rsp_year, rsp_month, rsp_day};
   assign rsp_tuser = rsp_flag;

endmodule

### tb/calendar_date_offset_core_test.sv
// calendar_date_offset_core_test: self-checking bench for the date offset core,
// a directed table then random words, with bursty requests and stalled results.
// Depends on cdo_pkg and calendar_date_offset_core.
module calendar_date_offset_core_test;
   import cdo_pkg::*;

   localparam int YEAR_SPAN    = 256;
   localparam int LAST_YEAR    = FIRST_YEAR + YEAR_SPAN - 1;
   localparam int GREG_START   = 1583;
   localparam int RANDOM_WORDS = 550;
   localparam int DRAIN_CYCLES = 2 * YEAR_SPAN + 64;
   localparam int LONG_HOLD    = 400;
   localparam int TIMEOUT      = 20_000_000;
   localparam bit DIR_ADD = 1'b0;
   localparam bit DIR_SUB = 1'b1;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic               direction;
      logic [AMT_W-1:0]   amount;
      logic [UNIT_W-1:0]  unit;
   } date_req_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic               out_of_range;
   } date_rsp_type;

   // one directed word, with its result typed in when known is set
   typedef struct packed {
      date_req_type rq;
      bit           known;
      date_rsp_type want;
   } date_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // start_day, start_month, start_year, direction, amount, zero pad
   logic [39:0] req_tdata;
   // unit
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // result_day, result_month, result_year, zero pad
   logic [23:0] rsp_tdata;
   // out_of_range
   logic [0:0]  rsp_tuser;

   date_rsp_type pending_dates[$];
   date_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           results_seen = 0;
   int           burst_left = 0;

   calendar_date_offset_core #(.YEAR_SPAN(YEAR_SPAN)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // calendar arithmetic
   function automatic bit is_leap(int y);
      if (y % 4 != 0)
         return 1'b0;
      if (y < GREG_START)
         return 1'b1;
      return !((y % 100 == 0) && (y % 400 != 0));
   endfunction

   function automatic int days_in_year(int y);
      return is_leap(y) ? 366 : 365;
   endfunction

   function automatic int days_in_month(int m, int y);
      case (m)
         2:             return is_leap(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // day count with 1 january of the first year as day 1
   function automatic int day_number(int d, int m, int y);
      int n;
      n = 0;
      for (int k = FIRST_YEAR; k < y; k++)
         n += days_in_year(k);
      for (int k = 1; k < m; k++)
         n += days_in_month(k, y);
      return n + d;
   endfunction

   function automatic date_rsp_type date_of_number(int n);
      int yy;
      int mm;
      date_rsp_type res;
      yy = FIRST_YEAR;
      mm = 1;
      while (n > days_in_year(yy)) begin
         n -= days_in_year(yy);
         yy++;
      end
      while (mm < 12 && n > days_in_month(mm, yy)) begin
         n -= days_in_month(mm, yy);
         mm++;
      end
      res.day = DAY_W'(n);
      res.month = MONTH_W'(mm);
      res.year = YEAR_W'(yy);
      res.out_of_range = 1'b0;
      return res;
   endfunction

   // expected result of one request word
   function automatic date_rsp_type shift_date(date_req_type rq);
      int d;
      int m;
      int y;
      int amt;
      int delta;
      int target;
      int new_year;
      date_rsp_type res;
      d = rq.day;
      m = rq.month;
      y = rq.year;
      amt = rq.amount;
      // start date echoed with the flag unless a move succeeds
      res.day = rq.day;
      res.month = rq.month;
      res.year = rq.year;
      res.out_of_range = 1'b1;
      if (m < 1 || m > 12 || y < FIRST_YEAR || y > LAST_YEAR || d < 1)
         return res;
      if (d > days_in_month(m, y))
         return res;
      case (rq.unit)
         UNIT_DAYS, UNIT_WEEKS: begin
            delta = (rq.unit == UNIT_WEEKS) ? amt * 7 : amt;
            target = rq.direction ? day_number(d, m, y) - delta
                                  : day_number(d, m, y) + delta;
            if (target >= 1 && target <= day_number(31, 12, LAST_YEAR))
               res = date_of_number(target);
         end
         UNIT_YEARS: begin
            new_year = rq.direction ? y - amt : y + amt;
            if (new_year >= FIRST_YEAR && new_year <= LAST_YEAR) begin
               res.year = YEAR_W'(new_year);
               res.out_of_range = 1'b0;
               // leap day landing in a common year
               if (m == 2 && d == 29 && !is_leap(new_year)) begin
                  res.day = DAY_FIRST;
                  res.month = MONTH_MAR;
               end
            end
         end
         default: begin
            res.out_of_range = 1'b0;
         end
      endcase
      return res;
   endfunction

   function automatic date_req_type req_of(int d, int m, int y, bit dir, int amt,
                                           logic [UNIT_W-1:0] unit);
      date_req_type rq;
      rq.day = DAY_W'(d);
      rq.month = MONTH_W'(m);
      rq.year = YEAR_W'(y);
      rq.direction = dir;
      rq.amount = AMT_W'(amt);
      rq.unit = unit;
      return rq;
   endfunction

   function automatic date_rsp_type rsp_of(int d, int m, int y, int oor);
      date_rsp_type rs;
      rs.day = DAY_W'(d);
      rs.month = MONTH_W'(m);
      rs.year = YEAR_W'(y);
      rs.out_of_range = (oor != 0);
      return rs;
   endfunction

   task automatic add_row(date_req_type rq, int known, date_rsp_type want);
      date_row_type row;
      row.rq = rq;
      row.known = (known != 0);
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // random request: mostly valid dates, some leap days and some raw noise
   function automatic date_req_type random_request();
      date_req_type rq;
      int pick;
      int y;
      int m;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         rq.day = DAY_W'($urandom);
         rq.month = MONTH_W'($urandom);
         rq.year = YEAR_W'($urandom);
      end else if (pick < 18) begin
         rq.day = DAY_LEAP;
         rq.month = MONTH_FEB;
         rq.year = YEAR_W'(4 * $urandom_range(476, 538));
      end else begin
         y = $urandom_range(FIRST_YEAR, LAST_YEAR);
         m = $urandom_range(1, 12);
         rq.year = YEAR_W'(y);
         rq.month = MONTH_W'(m);
         rq.day = DAY_W'($urandom_range(1, days_in_month(m, y)));
      end
      rq.direction = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         rq.unit = UNIT_DAYS;
         rq.amount = AMT_W'(($urandom_range(0, 9) < 6) ? $urandom_range(0, 400)
                                                       : $urandom_range(0, 65535));
      end else if (pick < 65) begin
         rq.unit = UNIT_WEEKS;
         rq.amount = AMT_W'(($urandom_range(0, 3) < 3) ? $urandom_range(0, 14000)
                                                       : $urandom_range(0, 65535));
      end else if (pick < 92) begin
         rq.unit = UNIT_YEARS;
         rq.amount = AMT_W'(($urandom_range(0, 4) < 4) ? $urandom_range(0, 260)
                                                       : $urandom_range(0, 65535));
      end else begin
         rq.unit = UNIT_NONE;
         rq.amount = AMT_W'($urandom_range(0, 65535));
      end
      return rq;
   endfunction

   // sender bursts: a gap of random length, sometimes none, opens each burst
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 2))
            0:       gap = 0;
            1:       gap = $urandom_range(1, 8);
            default: gap = $urandom_range(1, 300);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // offer one word and hold it until accepted
   task automatic offer_word(date_req_type rq);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, rq.amount, rq.direction, rq.year, rq.month, rq.day};
      req_tuser <= rq.unit;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // result checking against the oldest pending date
   always @(posedge clock) begin : rsp_check
      date_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_dates.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h/%h",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_dates.pop_front();
            check_field("result_day", want.day, rsp_tdata[4:0]);
            check_field("result_month", want.month, rsp_tdata[8:5]);
            check_field("result_year", want.year, rsp_tdata[20:9]);
            check_field("out_of_range", want.out_of_range, rsp_tuser[0]);
         end
      end
   end

   // result backpressure: runs of mixed stall rates and one long hold
   initial begin : rsp_pacing
      int run_len;
      int stall_pct;
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         run_len = $urandom_range(10, 80);
         case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
         endcase
         repeat (run_len) begin
            @(posedge clock);
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
         if (!held && results_seen >= 40) begin
            held = 1'b1;
            @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
      end
   end

   // stimulus: directed table, random words, then drain
   initial begin : stimulus
      date_req_type rq;
      clock = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // span ends and zero moves
      add_row(req_of(1, 1, 1900, DIR_ADD, 0, UNIT_DAYS), 1, rsp_of(1, 1, 1900, 0));
      add_row(req_of(31, 12, 2155, DIR_ADD, 0, UNIT_DAYS), 1, rsp_of(31, 12, 2155, 0));
      add_row(req_of(1, 1, 1900, DIR_SUB, 1, UNIT_DAYS), 1, rsp_of(1, 1, 1900, 1));
      add_row(req_of(31, 12, 2155, DIR_ADD, 1, UNIT_DAYS), 1, rsp_of(31, 12, 2155, 1));
      add_row(req_of(1, 1, 1900, DIR_ADD, 65535, UNIT_DAYS), 0, '0);
      add_row(req_of(31, 12, 2155, DIR_SUB, 65535, UNIT_DAYS), 0, '0);
      // invalid start dates
      add_row(req_of(0, 1, 2000, DIR_ADD, 5, UNIT_DAYS), 1, rsp_of(0, 1, 2000, 1));
      add_row(req_of(5, 0, 2000, DIR_ADD, 5, UNIT_DAYS), 1, rsp_of(5, 0, 2000, 1));
      add_row(req_of(31, 15, 2000, DIR_ADD, 5, UNIT_YEARS), 1, rsp_of(31, 15, 2000, 1));
      add_row(req_of(1, 1, 1899, DIR_ADD, 5, UNIT_DAYS), 1, rsp_of(1, 1, 1899, 1));
      add_row(req_of(1, 1, 2156, DIR_SUB, 5, UNIT_DAYS), 1, rsp_of(1, 1, 2156, 1));
      add_row(req_of(31, 12, 4095, DIR_SUB, 5, UNIT_WEEKS), 1, rsp_of(31, 12, 4095, 1));
      add_row(req_of(31, 4, 2000, DIR_ADD, 1, UNIT_DAYS), 1, rsp_of(31, 4, 2000, 1));
      add_row(req_of(29, 2, 1900, DIR_ADD, 1, UNIT_DAYS), 1, rsp_of(29, 2, 1900, 1));
      // month and year carries around leap years
      add_row(req_of(31, 12, 2000, DIR_ADD, 1, UNIT_DAYS), 1, rsp_of(1, 1, 2001, 0));
      add_row(req_of(31, 12, 1999, DIR_ADD, 1, UNIT_DAYS), 1, rsp_of(1, 1, 2000, 0));
      add_row(req_of(28, 2, 2000, DIR_ADD, 1, UNIT_DAYS), 1, rsp_of(29, 2, 2000, 0));
      add_row(req_of(1, 3, 1900, DIR_SUB, 1, UNIT_DAYS), 1, rsp_of(28, 2, 1900, 0));
      add_row(req_of(1, 1, 2000, DIR_ADD, 1, UNIT_WEEKS), 1, rsp_of(8, 1, 2000, 0));
      add_row(req_of(1, 1, 1900, DIR_ADD, 65535, UNIT_WEEKS), 1, rsp_of(1, 1, 1900, 1));
      // year shifts, leap day roll over and span limits
      add_row(req_of(29, 2, 2000, DIR_ADD, 100, UNIT_YEARS), 1, rsp_of(1, 3, 2100, 0));
      add_row(req_of(29, 2, 2000, DIR_ADD, 4, UNIT_YEARS), 1, rsp_of(29, 2, 2004, 0));
      add_row(req_of(1, 1, 1900, DIR_ADD, 255, UNIT_YEARS), 1, rsp_of(1, 1, 2155, 0));
      add_row(req_of(15, 6, 2155, DIR_SUB, 65535, UNIT_YEARS), 1, rsp_of(15, 6, 2155, 1));
      // unit code that moves nothing
      add_row(req_of(10, 10, 2010, DIR_SUB, 65535, UNIT_NONE), 1, rsp_of(10, 10, 2010, 0));

      foreach (directed_rows[i]) begin
         pace_sender();
         offer_word(directed_rows[i].rq);
         pending_dates.push_back(directed_rows[i].known ? directed_rows[i].want
                                                        : shift_date(directed_rows[i].rq));
      end

      repeat (RANDOM_WORDS) begin
         rq = random_request();
         pace_sender();
         offer_word(rq);
         pending_dates.push_back(shift_date(rq));
      end
      req_tvalid <= 1'b0;

      while (pending_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // hard stop for a hung run
   initial begin : watchdog
      #(TIMEOUT);
      $display("Mismatches found");
      $finish;
   end

endmodule
